### hdl/spq_pkg.sv
// Shared types and constants for the stable priority queue with duplicate filter.
// No dependencies; the top, the cell and the testbench import this package.
`default_nettype none

package spq_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned DataW     = 32;

	typedef enum logic {
		FN_INSERT = 1'b0,
		FN_REMOVE = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// request payload
	typedef struct packed {
		func_t                    func;
		logic signed [DataW-1:0]  item_value;
		logic signed [DataW-1:0]  item_priority;
	} req_t;

	// response payload
	typedef struct packed {
		logic signed [DataW-1:0]  out_value;
		status_t                  status;
	} rsp_t;

	// Wave that travels down the cell row, one cell per cycle.
	// Insert: value/prio are the new pair, hit = duplicate seen, placed = slot taken.
	// Remove: value/prio are the best pending entry so far, hit = one was found.
	typedef struct packed {
		logic                     vld;
		func_t                    func;
		logic signed [DataW-1:0]  value;
		logic signed [DataW-1:0]  prio;
		logic                     hit;
		logic                     placed;
	} wave_t;

	// Broadcast from the tail back to every cell when a remove commits.
	// (value, prio) is unique in a batch, so it names the slot to free.
	typedef struct packed {
		logic                     vld;
		logic                     batch_end;
		logic signed [DataW-1:0]  value;
		logic signed [DataW-1:0]  prio;
	} clr_t;

endpackage

`default_nettype wire

### hdl/spq_chan_if.sv
// Valid/ready channel interface with a typed payload.
// Payload type is set by the instantiating module (types from spq_pkg).
`default_nettype none

interface spq_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/stable_priority_queue_dedup.sv
// Top level of the stable priority queue with per-batch duplicate filter.
// Depends on spq_pkg, spq_chan_if and spq_cell.
`default_nettype none

// Usage
//   req : request channel (valid/ready). func = insert or remove, item_value and
//         item_priority are used by insert only.
//   rsp : one response per request, in order: out_value (removed value, else 0)
//         and status (inserted, duplicate, full, removed, empty).
// The slots form a row of DEPTH cells. A request enters as a wave at cell 0 and
// moves one cell per cycle; each cell checks for a duplicate, claims the first
// free slot, or updates the best pending entry (highest priority, earliest slot
// wins ties). At the end of the row the result is committed: the response is
// registered and a remove frees its slot by a broadcast to all cells.
// A request passes the cell registers, the tail register and the output
// register. One request is in the row at a time, so the row length sets the
// throughput. A new request is accepted as soon as the previous one has been
// committed, even while its response still waits in the output register.
// Receiver stall: a finished result waits at the row's tail until the output
// register frees; no response is lost or repeated.
// Reset: all slots free, pending count zero, no response pending; the slot
// contents are not cleared and are only read after being written.
module stable_priority_queue_dedup
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	spq_chan_if.sink   req,
	spq_chan_if.source rsp
);

	localparam int unsigned CntW = $clog2(DEPTH + 1);

	wave_t          wave [DEPTH+1];
	clr_t           clr;
	logic           busy_q;
	logic           done_vld_q;
	wave_t          done_q;
	logic [CntW-1:0] pend_q;
	logic           rsp_vld_q;
	rsp_t           rsp_q;
	rsp_t           result;
	logic           accept;
	logic           commit;
	logic           rm_ok;
	logic           ins_ok;

	// one request in flight; accept once the previous one has committed
	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;

	// wave entering the row
	always_comb begin
		wave[0].vld    = accept;
		wave[0].func   = req.data.func;
		wave[0].value  = req.data.item_value;
		wave[0].prio   = req.data.item_priority;
		wave[0].hit    = 1'b0;
		wave[0].placed = 1'b0;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wave_in  (wave[i]),
			.clr      (clr),
			.wave_out (wave[i+1])
		);
	end

	// tail: hold the finished wave until the output register can take it
	assign commit = done_vld_q && (!rsp_vld_q || rsp.ready);
	assign rm_ok  = (done_q.func == FN_REMOVE) && done_q.hit;
	assign ins_ok = (done_q.func == FN_INSERT) && !done_q.hit && done_q.placed;

	always_comb begin
		result.out_value = '0;
		if (done_q.func == FN_INSERT) begin
			if (done_q.hit) begin
				result.status = ST_DUP;
			end else if (done_q.placed) begin
				result.status = ST_INSERTED;
			end else begin
				result.status = ST_FULL;
			end
		end else begin
			if (done_q.hit) begin
				result.status    = ST_REMOVED;
				result.out_value = done_q.value;
			end else begin
				result.status = ST_EMPTY;
			end
		end
	end

	// free the removed slot; last pending entry ends the batch
	always_comb begin
		clr.vld       = commit && rm_ok;
		clr.batch_end = (pend_q == CntW'(1));
		clr.value     = done_q.value;
		clr.prio      = done_q.prio;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_vld_q <= 1'b0;
			pend_q     <= '0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end

			if (wave[DEPTH].vld) begin
				done_vld_q <= 1'b1;
			end else if (commit) begin
				done_vld_q <= 1'b0;
			end

			if (commit && ins_ok) begin
				pend_q <= pend_q + CntW'(1);
			end else if (commit && rm_ok) begin
				pend_q <= pend_q - CntW'(1);
			end

			if (commit) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wave[DEPTH].vld) begin
			done_q <= wave[DEPTH];
		end
		if (commit) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

endmodule

`default_nettype wire

### hdl/spq_cell.sv
// One slot of the queue: holds a (value, priority) pair and its flags,
// and processes the passing wave before handing it to the next slot. Uses spq_pkg.
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire wave_t wave_in,
	input  wire clr_t  clr,
	output wave_t      wave_out
);

	logic                    used_q;
	logic                    taken_q;
	logic signed [DataW-1:0] value_q;
	logic signed [DataW-1:0] prio_q;
	logic                    out_vld_q;
	wave_t                   out_q;

	logic  match;
	logic  place;
	logic  cand;
	logic  better;
	logic  clr_hit;
	wave_t nxt;

	assign match   = used_q && (value_q == wave_in.value) && (prio_q == wave_in.prio);
	assign place   = !used_q && !wave_in.hit && !wave_in.placed;
	assign cand    = used_q && taken_q;
	assign better  = cand && (!wave_in.hit || (prio_q > wave_in.prio));
	assign clr_hit = used_q && (value_q == clr.value) && (prio_q == clr.prio);

	always_comb begin
		nxt = wave_in;
		if (wave_in.func == FN_INSERT) begin
			nxt.hit    = wave_in.hit | match;
			nxt.placed = wave_in.placed | place;
		end else begin
			nxt.hit = wave_in.hit | cand;
			if (better) begin
				nxt.value = value_q;
				nxt.prio  = prio_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			taken_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= wave_in.vld;
			if (clr.vld && clr.batch_end) begin
				used_q  <= 1'b0;
				taken_q <= 1'b0;
			end else if (clr.vld && clr_hit) begin
				taken_q <= 1'b0;
			end else if (wave_in.vld && (wave_in.func == FN_INSERT) && place) begin
				used_q  <= 1'b1;
				taken_q <= 1'b1;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (wave_in.vld) begin
			out_q <= nxt;
			if ((wave_in.func == FN_INSERT) && place) begin
				value_q <= wave_in.value;
				prio_q  <= wave_in.prio;
			end
		end
	end

	always_comb begin
		wave_out     = out_q;
		wave_out.vld = out_vld_q;
	end

endmodule

`default_nettype wire

### tb/tb_stable_priority_queue_dedup.sv
// Self-checking testbench for stable_priority_queue_dedup: directed table, then random batches.
// Needs spq_pkg, spq_chan_if and the RTL top; predicts every response with an in-file shadow queue.

module tb_stable_priority_queue_dedup;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned Q_DEPTH   = DEPTH_DEF;
	localparam int          RAND_REQS = 400;
	localparam int          SQUEEZE   = 400;   // long receiver hold-off, in cycles
	localparam logic signed [DataW-1:0] V_MIN = {1'b1, {(DataW-1){1'b0}}};
	localparam logic signed [DataW-1:0] V_MAX = {1'b0, {(DataW-1){1'b1}}};

	// directed table row: request plus an optional hand-written answer
	typedef struct {
		req_t rq;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spq_chan_if #(.T(req_t)) req_if ();
	spq_chan_if #(.T(rsp_t)) rsp_if ();

	stable_priority_queue_dedup #(
		.DEPTH(Q_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the queue: slots fill in arrival order, so a lower
	// index is an older insert. Only slots below shadow_fill are ever read.
	logic signed [DataW-1:0] shadow_value [Q_DEPTH];
	logic signed [DataW-1:0] shadow_prio  [Q_DEPTH];
	bit                      shadow_live  [Q_DEPTH];
	int                      shadow_fill    = 0;
	int                      shadow_pending = 0;

	rsp_t     rsp_due [$];   // responses owed by the block, oldest first
	dir_row_t dir_rows [$];
	int       miss_cnt = 0;

	// random batch shaping
	bit drain_mode = 1'b1;   // start in drain so the first draw may open a batch or remove on empty
	bit full_batch = 1'b0;
	bit want_full  = 1'b1;   // first random batch is driven to full
	int ins_tries  = 0;
	int tries_goal = 0;
	int spill      = 0;

	// Apply one request to the shadow queue and return the response it earns.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t o;
		bit   dup;
		int   best;
		int   i;
		o.out_value = '0;
		if (r.func == FN_INSERT) begin
			dup = 1'b0;
			// the duplicate record covers removed entries of the batch too
			for (i = 0; i < shadow_fill; i++) begin
				if (shadow_value[i] == r.item_value && shadow_prio[i] == r.item_priority)
					dup = 1'b1;
			end
			if (dup) begin
				o.status = ST_DUP;   // wins over full
			end else if (shadow_fill >= Q_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				shadow_value[shadow_fill] = r.item_value;
				shadow_prio[shadow_fill]  = r.item_priority;
				shadow_live[shadow_fill]  = 1'b1;
				shadow_fill++;
				shadow_pending++;
				o.status = ST_INSERTED;
			end
		end else begin
			best = -1;
			// strict > keeps the earliest slot on equal priority
			for (i = 0; i < shadow_fill; i++) begin
				if (shadow_live[i] && (best < 0 || shadow_prio[i] > shadow_prio[best]))
					best = i;
			end
			if (best < 0) begin
				o.status = ST_EMPTY;
			end else begin
				o.out_value       = shadow_value[best];
				o.status          = ST_REMOVED;
				shadow_live[best] = 1'b0;
				shadow_pending--;
				// last pending entry gone: batch ends, duplicate record clears
				if (shadow_pending == 0) begin
					shadow_fill = 0;
					for (i = 0; i < Q_DEPTH; i++)
						shadow_live[i] = 1'b0;
				end
			end
		end
		return o;
	endfunction

	function automatic logic signed [DataW-1:0] pick_word();
		case ($urandom_range(9))
			0:       return V_MIN;
			1:       return V_MAX;
			2:       return ($urandom_range(1) != 0) ? 32'sd0 : -32'sd1;
			3, 4:    return int'($urandom_range(15)) - 8;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [DataW-1:0] pick_prio();
		case ($urandom_range(9))
			0:          return V_MIN;
			1:          return V_MAX;
			2, 3, 4, 5: return int'($urandom_range(4)) - 2;   // small pool, many ties
			default:    return $urandom;
		endcase
	endfunction

	// Next random request. Mostly well-formed batches: a fill stretch with
	// some removes mixed in, then a drain to empty; about one batch in five
	// is pushed past full, with duplicates offered against the full batch.
	function automatic req_t draw_request();
		req_t r;
		int   k;
		bit   as_dup;
		r.func          = FN_INSERT;
		r.item_value    = pick_word();
		r.item_priority = pick_prio();
		as_dup          = 1'b0;
		if (drain_mode && shadow_pending == 0) begin
			if ($urandom_range(2) == 0) begin
				r.func = FN_REMOVE;   // remove on empty
				return r;
			end
			drain_mode = 1'b0;
			full_batch = want_full || ($urandom_range(4) == 0);
			want_full  = 1'b0;
			ins_tries  = 0;
			spill      = 0;
			tries_goal = $urandom_range(16, 1);
		end
		if (!drain_mode) begin
			if (full_batch) begin
				if (shadow_fill >= Q_DEPTH) begin
					spill++;
					as_dup = spill[0];   // alternate duplicate and fresh on a full batch
					if (spill >= 6)
						drain_mode = 1'b1;
				end else begin
					as_dup = ($urandom_range(99) < 8);
				end
			end else if ($urandom_range(99) < 15) begin
				r.func = FN_REMOVE;
			end else begin
				as_dup = ($urandom_range(99) < 20);
				ins_tries++;
				if (ins_tries >= tries_goal)
					drain_mode = 1'b1;
			end
		end else if ($urandom_range(99) < 92) begin
			r.func = FN_REMOVE;
		end else begin
			as_dup = ($urandom_range(1) != 0);
		end
		if (r.func == FN_INSERT && as_dup && shadow_fill > 0) begin
			k               = $urandom_range(shadow_fill - 1);
			r.item_value    = shadow_value[k];
			r.item_priority = shadow_prio[k];
		end
		return r;
	endfunction

	task automatic add_row(input func_t f, input logic signed [DataW-1:0] v,
			input logic signed [DataW-1:0] p, input bit typed,
			input logic signed [DataW-1:0] wv, input status_t ws);
		dir_row_t row;
		row.rq.func          = f;
		row.rq.item_value    = v;
		row.rq.item_priority = p;
		row.typed            = typed;
		row.want.out_value   = wv;
		row.want.status      = ws;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// Sender, scoreboard push, end of run.
	initial begin
		int       total;
		int       made;
		int       acc_cnt;
		int       send_pct;
		int       p1;
		int       p2;
		bit       fire;
		bit       cur_typed;
		rsp_t     cur_want;
		rsp_t     owed;
		dir_row_t row;

		req_if.valid <= 1'b0;
		req_if.data  <= '0;

		// remove straight after reset
		add_row(FN_REMOVE, 32'sd0, 32'sd0, 1'b1, 32'sd0, ST_EMPTY);
		// extremes of both fields
		add_row(FN_INSERT, V_MAX, V_MAX, 1'b1, 32'sd0, ST_INSERTED);
		add_row(FN_INSERT, V_MIN, V_MIN, 1'b1, 32'sd0, ST_INSERTED);
		add_row(FN_INSERT, 32'sd0, 32'sd0, 1'b1, 32'sd0, ST_INSERTED);
		add_row(FN_INSERT, -32'sd1, 32'sd0, 1'b0, 32'sd0, ST_INSERTED);
		// same pair again while pending
		add_row(FN_INSERT, V_MAX, V_MAX, 1'b1, 32'sd0, ST_DUP);
		add_row(FN_INSERT, 32'sd5, 32'sd0, 1'b0, 32'sd0, ST_INSERTED);
		// same value, other priority: not a duplicate
		add_row(FN_INSERT, V_MAX, V_MIN, 1'b0, 32'sd0, ST_INSERTED);
		add_row(FN_REMOVE, 32'sd0, 32'sd0, 1'b1, V_MAX, ST_REMOVED);
		// removed pair still blocks within the batch
		add_row(FN_INSERT, V_MAX, V_MAX, 1'b1, 32'sd0, ST_DUP);
		// ties on priority 0, then on the minimum priority: oldest first
		add_row(FN_REMOVE, V_MAX, V_MIN, 1'b0, 32'sd0, ST_REMOVED);
		add_row(FN_REMOVE, 32'sd0, 32'sd0, 1'b0, 32'sd0, ST_REMOVED);
		add_row(FN_REMOVE, 32'sd0, 32'sd0, 1'b0, 32'sd0, ST_REMOVED);
		add_row(FN_REMOVE, 32'sd0, 32'sd0, 1'b0, 32'sd0, ST_REMOVED);
		add_row(FN_REMOVE, 32'sd0, 32'sd0, 1'b0, 32'sd0, ST_REMOVED);   // batch ends
		add_row(FN_REMOVE, -32'sd1, -32'sd1, 1'b1, 32'sd0, ST_EMPTY);
		// duplicate record cleared by the batch end
		add_row(FN_INSERT, V_MAX, V_MAX, 1'b1, 32'sd0, ST_INSERTED);
		add_row(FN_REMOVE, 32'sd0, 32'sd0, 1'b1, V_MAX, ST_REMOVED);

		total     = dir_rows.size() + RAND_REQS;
		p1        = dir_rows.size() + RAND_REQS / 3;
		p2        = dir_rows.size() + (2 * RAND_REQS) / 3;
		made      = 0;
		acc_cnt   = 0;
		cur_typed = 1'b0;
		cur_want  = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (acc_cnt < total) begin
			@(posedge clk);
			fire = req_if.valid && req_if.ready;
			if (fire) begin
				// predictor always runs so the shadow state tracks the block
				owed = apply_request(req_if.data);
				rsp_due.insert(rsp_due.size(), cur_typed ? cur_want : owed);
				acc_cnt++;
			end
			// idle mix: receiver lazy first, then sender lazy, then none
			send_pct = (made < p1) ? 37 : (made < p2) ? 78 : 0;
			// a request already on the bus holds until taken
			if (!req_if.valid || fire) begin
				if (made < total && $urandom_range(99) >= send_pct) begin
					if (made < dir_rows.size()) begin
						row          = dir_rows[made];
						req_if.data  <= row.rq;
						cur_typed    = row.typed;
						cur_want     = row.want;
					end else begin
						req_if.data  <= draw_request();
						cur_typed    = 1'b0;
					end
					req_if.valid <= 1'b1;
					made++;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end

		while (rsp_due.size() != 0)
			@(posedge clk);
		// room for a stray extra response to show up
		repeat (Q_DEPTH + 8) @(posedge clk);

		if (miss_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Receiver: checks each response against the oldest owed one.
	initial begin
		int   rsp_seen;
		int   recv_pct;
		int   hold_left;
		int   p1;
		int   p2;
		bit   squeezed;
		rsp_t got;
		rsp_t want;

		rsp_if.ready <= 1'b0;
		rsp_seen  = 0;
		hold_left = 0;
		squeezed  = 1'b0;
		p1        = 18 + RAND_REQS / 3;
		p2        = 18 + (2 * RAND_REQS) / 3;

		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				rsp_seen++;
				if (rsp_due.size() == 0) begin
					miss_cnt++;
					if (miss_cnt <= 10)
						$display("unexpected response: out_value=%0d status=%0d",
							got.out_value, got.status);
				end else begin
					want = rsp_due.pop_front();
					if (got.out_value !== want.out_value || got.status !== want.status) begin
						miss_cnt++;
						if (miss_cnt <= 10)
							$display("mismatch #%0d: out_value exp %0d got %0d, status exp %0d got %0d",
								rsp_seen, want.out_value, got.out_value,
								want.status, got.status);
					end
				end
			end
			recv_pct = (rsp_seen < p1) ? 78 : (rsp_seen < p2) ? 37 : 0;
			// once, early in the last phase: hold off long enough to back up the input
			if (!squeezed && rsp_seen >= p2 + 10) begin
				squeezed  = 1'b1;
				hold_left = SQUEEZE;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_pct);
			end
		end
	end

	// hang guard
	initial begin
		#(10_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule
